// ----- rtl/tcw_pkg.sv -----
// tcw_pkg: shared types, codes and constants of the text console writer
// used by tcw_ctrl, tcw_datapath and text_console_writer_top; no dependencies

package tcw_pkg;

	// default geometry
	localparam int DEF_COLUMNS   = 80;
	localparam int DEF_ROWS      = 25;
	localparam int DEF_TAB_WIDTH = 4;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int PCOL_W   = 7;
	localparam int PROW_W   = 5;
	localparam int OCOL_W   = 7;
	localparam int OROW_W   = 5;
	localparam int OFS_W    = 11;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	// character and attribute constants
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_STREAM = 2'd0,
		CMD_PLACE  = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// screen memory operations
	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_PUT_CHAR,
		MOP_PUT_SPACE,
		MOP_PLACE,
		MOP_FILL,
		MOP_COPY_RD,
		MOP_READ
	} mop_t;

	// cursor operations
	typedef enum logic [2:0] {
		CUR_NONE,
		CUR_STEP,
		CUR_NEWLINE,
		CUR_BACK,
		CUR_HOME
	} cur_op_t;

	// controller to datapath
	typedef struct packed {
		logic    load_item;
		mop_t    mop;
		cur_op_t cur_op;
		logic    fill_init;
		logic    sweep_clr;
		logic    sweep_inc;
		logic    tab_clr;
		logic    tab_inc;
		logic    out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic is_newline;
		logic is_backspace;
		logic is_tab;
		logic col_last;
		logic row_last;
		logic at_origin;
		logic tab_last;
		logic sweep_copy_end;
		logic sweep_end;
		logic out_free;
	} dp_status_t;

endpackage

// ----- rtl/tcw_ctrl.sv -----
// tcw_ctrl: command sequencer of the text console writer
// depends on tcw_pkg for command, operation and status types

module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tcw_pkg::dp_status_t status,
	output tcw_pkg::ctrl_cmd_t  ctl
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_PUT,
		ST_BS_BLANK,
		ST_COPY,
		ST_BLANK_ROW,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   more_q, more_d;

	assign in_stall = (state_q != ST_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d       = state_q;
		more_d        = more_q;
		ctl           = '0;
		ctl.mop       = tcw_pkg::MOP_NONE;
		ctl.cur_op    = tcw_pkg::CUR_NONE;
		unique case (state_q)
			ST_INIT: begin
				// screen clearing pass after reset
				ctl.mop       = tcw_pkg::MOP_FILL;
				ctl.fill_init = 1'b1;
				ctl.sweep_inc = 1'b1;
				if (status.sweep_end) begin
					ctl.sweep_clr = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_d       = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				ctl.tab_clr = 1'b1;
				unique case (status.cmd)
					tcw_pkg::CMD_STREAM: begin
						if (status.is_newline) begin
							ctl.cur_op = tcw_pkg::CUR_NEWLINE;
							if (status.row_last) begin
								ctl.sweep_clr = 1'b1;
								more_d        = 1'b0;
								state_d       = ST_COPY;
							end else begin
								state_d = ST_DONE;
							end
						end else if (status.is_backspace) begin
							if (status.at_origin) begin
								state_d = ST_DONE;
							end else begin
								ctl.cur_op = tcw_pkg::CUR_BACK;
								state_d    = ST_BS_BLANK;
							end
						end else begin
							state_d = ST_PUT;
						end
					end
					tcw_pkg::CMD_PLACE: begin
						ctl.mop = tcw_pkg::MOP_PLACE;
						state_d = ST_DONE;
					end
					tcw_pkg::CMD_CLEAR: begin
						ctl.sweep_clr = 1'b1;
						state_d       = ST_CLEAR;
					end
					tcw_pkg::CMD_READ: begin
						ctl.mop = tcw_pkg::MOP_READ;
						state_d = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_PUT: begin
				// one character or one tab space at the cursor
				ctl.mop     = status.is_tab ? tcw_pkg::MOP_PUT_SPACE : tcw_pkg::MOP_PUT_CHAR;
				ctl.cur_op  = tcw_pkg::CUR_STEP;
				ctl.tab_inc = 1'b1;
				if (status.col_last && status.row_last) begin
					ctl.sweep_clr = 1'b1;
					more_d        = status.is_tab && !status.tab_last;
					state_d       = ST_COPY;
				end else if (status.is_tab && !status.tab_last) begin
					state_d = ST_PUT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_BS_BLANK: begin
				ctl.mop = tcw_pkg::MOP_PUT_SPACE;
				state_d = ST_DONE;
			end
			ST_COPY: begin
				// move every row up; last cycle only drains the pending write
				if (status.sweep_copy_end) begin
					state_d = ST_BLANK_ROW;
				end else begin
					ctl.mop       = tcw_pkg::MOP_COPY_RD;
					ctl.sweep_inc = 1'b1;
				end
			end
			ST_BLANK_ROW: begin
				ctl.mop       = tcw_pkg::MOP_FILL;
				ctl.sweep_inc = 1'b1;
				if (status.sweep_end) begin
					ctl.sweep_clr = 1'b1;
					state_d       = more_q ? ST_PUT : ST_DONE;
				end
			end
			ST_CLEAR: begin
				ctl.mop       = tcw_pkg::MOP_FILL;
				ctl.sweep_inc = 1'b1;
				if (status.sweep_end) begin
					ctl.sweep_clr = 1'b1;
					ctl.cur_op    = tcw_pkg::CUR_HOME;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			more_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			more_q  <= more_d;
		end
	end

endmodule

// ----- rtl/tcw_datapath.sv -----
// tcw_datapath: screen memory, cursor, color register, counters and result register
// depends on tcw_pkg for types and constants; driven by tcw_ctrl

module tcw_datapath #(
	parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tcw_pkg::DEF_ROWS,
	parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcw_pkg::ctrl_cmd_t                ctl,
	output tcw_pkg::dp_status_t               status,
	input  logic                              cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data,
	input  logic [tcw_pkg::CMD_W-1:0]         cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  logic [tcw_pkg::PCOL_W-1:0]        place_col,
	input  logic [tcw_pkg::PROW_W-1:0]        place_row,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcw_pkg::OCOL_W-1:0]        cursor_col,
	output logic [tcw_pkg::OROW_W-1:0]        cursor_row,
	output logic [tcw_pkg::OFS_W-1:0]         cursor_offset,
	output logic [tcw_pkg::CHAR_W-1:0]        cell_char,
	output logic [tcw_pkg::ATTR_W-1:0]        cell_attr
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int TAB_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int CW     = tcw_pkg::CELL_W;

	logic [CW-1:0] mem [CELLS];

	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [tcw_pkg::ATTR_W-1:0] color_q;
	tcw_pkg::cmd_t     cmd_q;
	logic [tcw_pkg::CHAR_W-1:0] char_q;
	logic [tcw_pkg::PCOL_W-1:0] pc_q;
	logic [tcw_pkg::PROW_W-1:0] pr_q;
	logic              inside_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [TAB_W-1:0]  tab_q;
	logic [CW-1:0]     rd_q;
	logic              copy_pend_s1;
	logic [ADDR_W-1:0] copy_addr_s1;
	logic              out_valid_q;

	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] place_addr;
	logic              in_inside;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CW-1:0]     wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [tcw_pkg::ATTR_W-1:0] fill_attr;

	// cell addresses
	assign cur_addr   = ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q);
	assign place_addr = ADDR_W'(ROW_W'(pr_q)) * ADDR_W'(COLUMNS) + ADDR_W'(COL_W'(pc_q));
	assign in_inside  = (32'(place_col) < 32'(COLUMNS)) && (32'(place_row) < 32'(ROWS));
	assign fill_attr  = ctl.fill_init ? tcw_pkg::RESET_ATTR : color_q;

	// status to the controller
	assign status.cmd            = cmd_q;
	assign status.is_newline     = (char_q == tcw_pkg::CH_NEWLINE);
	assign status.is_backspace   = (char_q == tcw_pkg::CH_BACKSPACE);
	assign status.is_tab         = (char_q == tcw_pkg::CH_TAB);
	assign status.col_last       = (cur_col_q == COL_W'(COLUMNS - 1));
	assign status.row_last       = (cur_row_q == ROW_W'(ROWS - 1));
	assign status.at_origin      = (cur_col_q == '0) && (cur_row_q == '0);
	assign status.tab_last       = (tab_q == TAB_W'(TAB_WIDTH - 1));
	assign status.sweep_copy_end = (sweep_q == ADDR_W'(CELLS - COLUMNS));
	assign status.sweep_end      = (sweep_q == ADDR_W'(CELLS - 1));
	assign status.out_free       = !out_valid_q || !out_stall;

	// memory port selection; a pending copy write owns the write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_addr;
		wr_data = {color_q, tcw_pkg::BLANK_CHAR};
		rd_en   = 1'b0;
		rd_addr = place_addr;
		case (ctl.mop)
			tcw_pkg::MOP_PUT_CHAR: begin
				wr_en   = 1'b1;
				wr_data = {color_q, char_q};
			end
			tcw_pkg::MOP_PUT_SPACE: begin
				wr_en = 1'b1;
			end
			tcw_pkg::MOP_PLACE: begin
				wr_en   = inside_q;
				wr_addr = place_addr;
				wr_data = {color_q, char_q};
			end
			tcw_pkg::MOP_FILL: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = {fill_attr, tcw_pkg::BLANK_CHAR};
			end
			tcw_pkg::MOP_COPY_RD: begin
				rd_en   = 1'b1;
				rd_addr = sweep_q + ADDR_W'(COLUMNS);
			end
			tcw_pkg::MOP_READ: begin
				rd_en = inside_q;
			end
			default: ;
		endcase
		if (copy_pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = copy_addr_s1;
			wr_data = rd_q;
		end
	end

	// screen memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q    <= tcw_pkg::cmd_t'(cmd);
			char_q   <= char_code;
			pc_q     <= place_col;
			pr_q     <= place_row;
			inside_q <= in_inside;
		end
		copy_addr_s1 <= sweep_q;
	end

	// cursor, color, counters and copy pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			color_q      <= tcw_pkg::RESET_ATTR;
			sweep_q      <= '0;
			tab_q        <= '0;
			copy_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_data;
			end
			copy_pend_s1 <= (ctl.mop == tcw_pkg::MOP_COPY_RD);
			if (ctl.sweep_clr) begin
				sweep_q <= '0;
			end else if (ctl.sweep_inc) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (ctl.tab_clr) begin
				tab_q <= '0;
			end else if (ctl.tab_inc) begin
				tab_q <= tab_q + 1'b1;
			end
			case (ctl.cur_op)
				tcw_pkg::CUR_STEP: begin
					if (status.col_last) begin
						cur_col_q <= '0;
						if (!status.row_last) begin
							cur_row_q <= cur_row_q + 1'b1;
						end
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				tcw_pkg::CUR_NEWLINE: begin
					cur_col_q <= '0;
					if (!status.row_last) begin
						cur_row_q <= cur_row_q + 1'b1;
					end
				end
				tcw_pkg::CUR_BACK: begin
					if (cur_col_q == '0) begin
						cur_col_q <= COL_W'(COLUMNS - 1);
						cur_row_q <= cur_row_q - 1'b1;
					end else begin
						cur_col_q <= cur_col_q - 1'b1;
					end
				end
				tcw_pkg::CUR_HOME: begin
					cur_col_q <= '0;
					cur_row_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			cursor_col    <= tcw_pkg::OCOL_W'(cur_col_q);
			cursor_row    <= tcw_pkg::OROW_W'(cur_row_q);
			cursor_offset <= tcw_pkg::OFS_W'(cur_addr);
			if ((cmd_q == tcw_pkg::CMD_READ) && inside_q) begin
				cell_char <= rd_q[tcw_pkg::CHAR_W-1:0];
				cell_attr <= rd_q[CW-1:tcw_pkg::CHAR_W];
			end else begin
				cell_char <= '0;
				cell_attr <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/text_console_writer_top.sv -----
// text_console_writer_top: text console writer, controller plus datapath
// depends on tcw_pkg, tcw_ctrl and tcw_datapath
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   in       | in_valid/in_stall  | cmd, char_code, place_col, place_row
//   out      | out_valid/out_stall| cursor_col, cursor_row, cursor_offset,
//            |                    | cell_char, cell_attr
//   cfg      | cfg_we             | cfg_data (text_color)
//
// a plain character passes the DISPATCH, PUT and DONE states, a backspace DISPATCH,
// BS_BLANK and DONE, a newline, place or read DISPATCH and DONE; a tab repeats PUT
// once per tab space; a scroll adds COPY and BLANK_ROW sweeps, a clear a CLEAR sweep
// after reset a clearing pass over all COLUMNS*ROWS cells runs with in_stall high
// one result may wait in the output register while the next item is taken

module text_console_writer_top #(
	parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tcw_pkg::DEF_ROWS,
	parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tcw_pkg::CMD_W-1:0]  cmd,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::PCOL_W-1:0] place_col,
	input  logic [tcw_pkg::PROW_W-1:0] place_row,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tcw_pkg::OCOL_W-1:0] cursor_col,
	output logic [tcw_pkg::OROW_W-1:0] cursor_row,
	output logic [tcw_pkg::OFS_W-1:0]  cursor_offset,
	output logic [tcw_pkg::CHAR_W-1:0] cell_char,
	output logic [tcw_pkg::ATTR_W-1:0] cell_attr
);

	tcw_pkg::ctrl_cmd_t  ctl;
	tcw_pkg::dp_status_t status;

	// sequencer
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	// screen and cursor datapath
	tcw_datapath #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.char_code     (char_code),
		.place_col     (place_col),
		.place_row     (place_row),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.cursor_offset (cursor_offset),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr)
	);

endmodule

// ----- tb/sv/tb_text_console_writer_top.sv -----
// tb_text_console_writer_top: self-checking testbench of the text console writer
// depends on tcw_pkg and text_console_writer_top; keeps a shadow screen and cursor
// and checks every cursor report and cell read against it

module tb_text_console_writer_top;

	localparam int COLS  = tcw_pkg::DEF_COLUMNS;
	localparam int ROWS  = tcw_pkg::DEF_ROWS;
	localparam int TABW  = tcw_pkg::DEF_TAB_WIDTH;
	localparam int CELLS = COLS * ROWS;

	// one command offered to the console
	typedef struct {
		tcw_pkg::cmd_t               op;
		logic [tcw_pkg::CHAR_W-1:0]  ch;
		logic [tcw_pkg::PCOL_W-1:0]  col;
		logic [tcw_pkg::PROW_W-1:0]  row;
	} console_item_t;

	// one cursor report returned by the console
	typedef struct {
		logic [tcw_pkg::OCOL_W-1:0]  ccol;
		logic [tcw_pkg::OROW_W-1:0]  crow;
		logic [tcw_pkg::OFS_W-1:0]   ofs;
		logic [tcw_pkg::CHAR_W-1:0]  ch;
		logic [tcw_pkg::ATTR_W-1:0]  attr;
	} cursor_report_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [tcw_pkg::ATTR_W-1:0]   cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [tcw_pkg::CMD_W-1:0]    cmd = '0;
	logic [tcw_pkg::CHAR_W-1:0]   char_code = '0;
	logic [tcw_pkg::PCOL_W-1:0]   place_col = '0;
	logic [tcw_pkg::PROW_W-1:0]   place_row = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [tcw_pkg::OCOL_W-1:0]   cursor_col;
	logic [tcw_pkg::OROW_W-1:0]   cursor_row;
	logic [tcw_pkg::OFS_W-1:0]    cursor_offset;
	logic [tcw_pkg::CHAR_W-1:0]   cell_char;
	logic [tcw_pkg::ATTR_W-1:0]   cell_attr;

	// shadow copy of the console state
	logic [tcw_pkg::CELL_W-1:0]   shadow_cells [CELLS];
	int                           shadow_col;
	int                           shadow_row;
	logic [tcw_pkg::ATTR_W-1:0]   shadow_color;

	console_item_t       pending_cmds [$];
	cursor_report_t      reports_due [$];
	console_item_t       offered;
	int                  sender_gap = 0;
	int                  stall_left = 0;
	int                  hold_cnt = 0;
	bit                  hold_done = 1'b0;
	bit                  long_hold_req = 1'b0;
	bit                  quiet = 1'b0;
	int                  mismatches = 0;

	text_console_writer_top #(
		.COLUMNS   (COLS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TABW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.char_code     (char_code),
		.place_col     (place_col),
		.place_row     (place_row),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.cursor_offset (cursor_offset),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// blank the whole shadow screen
	function automatic void shadow_fill(logic [tcw_pkg::ATTR_W-1:0] attr);
		for (int k = 0; k < CELLS; k++)
			shadow_cells[k] = {attr, tcw_pkg::BLANK_CHAR};
	endfunction

	// next row, scrolling the screen up when already on the last row
	function automatic void shadow_next_row();
		if (shadow_row + 1 < ROWS) begin
			shadow_row++;
		end else begin
			for (int k = 0; k < CELLS - COLS; k++)
				shadow_cells[k] = shadow_cells[k + COLS];
			for (int k = CELLS - COLS; k < CELLS; k++)
				shadow_cells[k] = {shadow_color, tcw_pkg::BLANK_CHAR};
			shadow_row = ROWS - 1;
		end
	endfunction

	// write one character at the cursor and advance, wrapping at the last column
	function automatic void shadow_put(logic [tcw_pkg::CHAR_W-1:0] ch);
		shadow_cells[shadow_row * COLS + shadow_col] = {shadow_color, ch};
		shadow_col++;
		if (shadow_col >= COLS) begin
			shadow_col = 0;
			shadow_next_row();
		end
	endfunction

	// apply one command to the shadow console and form the cursor report
	function automatic cursor_report_t screen_predict(console_item_t it);
		cursor_report_t r;
		logic [tcw_pkg::CELL_W-1:0] c;
		bit on_screen;
		on_screen = (int'(it.col) < COLS) && (int'(it.row) < ROWS);
		r.ch = '0;
		r.attr = '0;
		case (it.op)
			tcw_pkg::CMD_STREAM: begin
				if (it.ch == tcw_pkg::CH_NEWLINE) begin
					shadow_col = 0;
					shadow_next_row();
				end else if (it.ch == tcw_pkg::CH_BACKSPACE) begin
					// nothing to erase at the origin
					if (shadow_col != 0 || shadow_row != 0) begin
						if (shadow_col == 0) begin
							shadow_col = COLS - 1;
							shadow_row--;
						end else begin
							shadow_col--;
						end
						shadow_cells[shadow_row * COLS + shadow_col] =
							{shadow_color, tcw_pkg::BLANK_CHAR};
					end
				end else if (it.ch == tcw_pkg::CH_TAB) begin
					for (int k = 0; k < TABW; k++)
						shadow_put(tcw_pkg::BLANK_CHAR);
				end else begin
					shadow_put(it.ch);
				end
			end
			tcw_pkg::CMD_PLACE: begin
				if (on_screen)
					shadow_cells[int'(it.row) * COLS + int'(it.col)] = {shadow_color, it.ch};
			end
			tcw_pkg::CMD_CLEAR: begin
				shadow_fill(shadow_color);
				shadow_col = 0;
				shadow_row = 0;
			end
			default: begin
				if (on_screen) begin
					c = shadow_cells[int'(it.row) * COLS + int'(it.col)];
					r.ch = c[tcw_pkg::CHAR_W-1:0];
					r.attr = c[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
				end
			end
		endcase
		r.ccol = shadow_col[tcw_pkg::OCOL_W-1:0];
		r.crow = shadow_row[tcw_pkg::OROW_W-1:0];
		r.ofs = tcw_pkg::OFS_W'(shadow_row * COLS + shadow_col);
		return r;
	endfunction

	// input driver: offers queued commands, predicts each transfer
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			reports_due.push_back(screen_predict(offered));
		if (!in_valid || !in_stall) begin
			if (sender_gap > 0) begin
				sender_gap--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				offered = pending_cmds.pop_front();
				in_valid <= 1'b1;
				cmd <= offered.op;
				char_code <= offered.ch;
				place_col <= offered.col;
				place_row <= offered.row;
				if (!quiet && $urandom_range(0, 3) == 0)
					sender_gap = $urandom_range(1, 7);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted on its own
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (long_hold_req && !hold_done) begin
			hold_cnt <= 400;
			hold_done <= 1'b1;
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!quiet && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 7);
		out_stall <= (stall_left > 0) || (hold_cnt > 1);
	end

	// count a mismatch, print only the first few
	function automatic void note_mismatch(string what, int expv, int gotv);
		mismatches++;
		if (mismatches <= 10)
			$display("tb: mismatch on %s: expected %0d, got %0d", what, expv, gotv);
	endfunction

	// output monitor: compare each transfer with the oldest expected report
	always @(posedge clk) begin
		cursor_report_t e;
		if (out_valid === 1'b1 && !out_stall) begin
			if (reports_due.size() == 0) begin
				note_mismatch("unexpected report count", 0, 1);
			end else begin
				e = reports_due.pop_front();
				if (cursor_col !== e.ccol)
					note_mismatch("cursor_col", e.ccol, cursor_col);
				if (cursor_row !== e.crow)
					note_mismatch("cursor_row", e.crow, cursor_row);
				if (cursor_offset !== e.ofs)
					note_mismatch("cursor_offset", e.ofs, cursor_offset);
				if (cell_char !== e.ch)
					note_mismatch("cell_char", e.ch, cell_char);
				if (cell_attr !== e.attr)
					note_mismatch("cell_attr", e.attr, cell_attr);
			end
		end
	end

	// watchdog
	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic queue_cmd(tcw_pkg::cmd_t op, int ch, int col, int row);
		console_item_t it;
		it.op = op;
		it.ch = tcw_pkg::CHAR_W'(ch);
		it.col = tcw_pkg::PCOL_W'(col);
		it.row = tcw_pkg::PROW_W'(row);
		pending_cmds.push_back(it);
	endtask

	// stream command with random don't-care cell fields
	task automatic queue_stream(int ch);
		queue_cmd(tcw_pkg::CMD_STREAM, ch, $urandom_range(0, 127), $urandom_range(0, 31));
	endtask

	// random command; nl_pct sets how often a stream character is a newline
	task automatic queue_random(int nl_pct);
		int pick;
		int kind;
		int col;
		int row;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			col = $urandom_range(0, 127);
			row = $urandom_range(0, 31);
		end else begin
			col = $urandom_range(0, COLS - 1);
			row = $urandom_range(0, ROWS - 1);
		end
		if (pick < 72) begin
			kind = $urandom_range(0, 99);
			if (kind < nl_pct)
				queue_stream(tcw_pkg::CH_NEWLINE);
			else if (kind < nl_pct + 8)
				queue_stream(tcw_pkg::CH_BACKSPACE);
			else if (kind < nl_pct + 13)
				queue_stream(tcw_pkg::CH_TAB);
			else
				queue_stream($urandom_range(0, 255));
		end else if (pick < 82) begin
			queue_cmd(tcw_pkg::CMD_PLACE, $urandom_range(0, 255), col, row);
		end else if (pick < 98) begin
			queue_cmd(tcw_pkg::CMD_READ, $urandom_range(0, 255), col, row);
		end else begin
			queue_cmd(tcw_pkg::CMD_CLEAR, $urandom_range(0, 255), col, row);
		end
	endtask

	// wait until every queued command has been transferred and answered
	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || reports_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// write the color register while the console is idle
	task automatic write_color(logic [tcw_pkg::ATTR_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_color = v;
	endtask

	// reset, then directed commands, then random phases under several colors
	initial begin
		shadow_fill(tcw_pkg::RESET_ATTR);
		shadow_col = 0;
		shadow_row = 0;
		shadow_color = tcw_pkg::RESET_ATTR;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads of the blank screen, corners and out of range
		queue_cmd(tcw_pkg::CMD_READ, 0, 0, 0);
		queue_cmd(tcw_pkg::CMD_READ, 255, COLS - 1, ROWS - 1);
		queue_cmd(tcw_pkg::CMD_READ, 0, COLS, 0);
		queue_cmd(tcw_pkg::CMD_READ, 0, 0, ROWS);
		queue_cmd(tcw_pkg::CMD_READ, 0, 127, 31);
		// backspace at the origin, extreme bytes, tab, newline
		queue_stream(tcw_pkg::CH_BACKSPACE);
		queue_stream(65);
		queue_stream(0);
		queue_stream(255);
		queue_stream(tcw_pkg::CH_TAB);
		queue_stream(tcw_pkg::CH_NEWLINE);
		// backspace from column 0 wraps to the end of the previous row
		queue_stream(tcw_pkg::CH_BACKSPACE);
		queue_cmd(tcw_pkg::CMD_READ, 0, COLS - 1, 0);
		// place with raw control code, out of range places, extreme byte
		queue_cmd(tcw_pkg::CMD_PLACE, tcw_pkg::CH_NEWLINE, COLS - 1, ROWS - 1);
		queue_cmd(tcw_pkg::CMD_PLACE, 66, COLS, 3);
		queue_cmd(tcw_pkg::CMD_PLACE, 67, 0, 31);
		queue_cmd(tcw_pkg::CMD_PLACE, 255, 0, 0);
		queue_cmd(tcw_pkg::CMD_READ, 0, COLS - 1, ROWS - 1);
		queue_cmd(tcw_pkg::CMD_READ, 0, 0, 0);
		queue_cmd(tcw_pkg::CMD_READ, 0, 3, 0);
		// clear and check the screen afterwards
		queue_cmd(tcw_pkg::CMD_CLEAR, 0, 127, 31);
		queue_cmd(tcw_pkg::CMD_READ, 0, COLS - 1, ROWS - 1);
		queue_stream(90);
		drain();

		write_color(8'h00);
		repeat (170) queue_random(10);
		drain();

		// long lines force wraps and scrolls after a wrap; receiver holds off
		write_color(8'hFF);
		long_hold_req <= 1'b1;
		repeat (180) queue_random(1);
		drain();

		write_color(8'($urandom_range(1, 254)));
		repeat (170) queue_random(5);
		drain();

		write_color(8'($urandom_range(1, 254)));
		repeat (170) queue_random(15);
		drain();

		// final stretch without any idling
		write_color(8'($urandom_range(0, 255)));
		quiet = 1'b1;
		repeat (200) queue_random(3);
		drain();

		if (mismatches == 0 && reports_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
